>>> hdl/sacbp_pkg.sv
`default_nettype none
package sacbp_pkg;
  localparam int unsigned MaxSetBits = 8;
  localparam int unsigned MaxWays = 8;
  localparam int unsigned AddrBits = 48;
  localparam int unsigned CntW = 32;

  // configuration register indexes
  localparam logic [1:0] RegPolicy = 2'd0;
  localparam logic [1:0] RegOffset = 2'd1;
  localparam logic [1:0] RegSetBits = 2'd2;
  localparam logic [1:0] RegWayBits = 2'd3;

  localparam logic PolicyAlloc = 1'b0;
  localparam logic OpWrite = 1'b1;

  // saturating increment
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v, input logic en);
    logic [CntW-1:0] r;
    r = v;
    if (en && (v != {CntW{1'b1}})) r = v + CntW'(1);
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hdl/set_assoc_cache_bit_plru.sv
// channel | handshake            | fields
// cfg     | cfg_valid_i/_ready_o | cfg_index_i, cfg_data_i
// in      | in_valid_i/_ready_o  | operation_i, address_i
// out     | out_valid_o/_ready_i | hit_o, memory_access_o, filled_o, *_count_o
// For each word the accept edge reads the set row from the tag
// and line-state memories, the next edge compares, picks the way and writes
// back. A new word is taken only when no word is being compared and the
// output register is empty or is being drained in the same cycle, so a
// stalled result blocks the input. After reset a clearing pass over every set
// zeroes the valid bits, marks and mark counts; input is held off until done.
`default_nettype none
module set_assoc_cache_bit_plru #(
  parameter int unsigned MAX_SET_BITS = sacbp_pkg::MaxSetBits,
  parameter int unsigned MAX_WAYS = sacbp_pkg::MaxWays,
  parameter int unsigned ADDR_BITS = sacbp_pkg::AddrBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [3:0]           cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 operation_i,
  input  wire logic [ADDR_BITS-1:0] address_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      hit_o,
  output logic                      memory_access_o,
  output logic                      filled_o,
  output logic [31:0]               hit_count_o,
  output logic [31:0]               memory_count_o,
  output logic [31:0]               lookup_count_o
);
  localparam int unsigned NSets = 1 << MAX_SET_BITS;
  localparam int unsigned SetW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CntW = sacbp_pkg::CntW;
  localparam int unsigned MetaW = 4 + 2 * MAX_WAYS;

  // configuration registers
  logic       policy_q;
  logic [3:0] offset_q, setb_q;
  logic [1:0] wayb_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
      offset_q <= 4'd5;
      setb_q <= 4'd8;
      wayb_q <= 2'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sacbp_pkg::RegPolicy: policy_q <= cfg_data_i[0];
        sacbp_pkg::RegOffset: offset_q <= cfg_data_i;
        sacbp_pkg::RegSetBits: setb_q <= cfg_data_i;
        sacbp_pkg::RegWayBits: wayb_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // address decode
  logic [4:0]           sbits;
  logic [SetW-1:0]      set_in;
  logic [ADDR_BITS-1:0] tag_in, sh_addr;
  logic [5:0]           sh_total;
  always_comb begin
    sbits = (32'(setb_q) > MAX_SET_BITS) ? 5'(MAX_SET_BITS) : {1'b0, setb_q};
    sh_addr = address_i >> offset_q;
    set_in = SetW'(sh_addr & ((ADDR_BITS'(1) << sbits) - ADDR_BITS'(1)));
    sh_total = {2'b0, offset_q} + {1'b0, sbits};
    tag_in = address_i >> sh_total;
  end

  // clearing pass over the line-state memory after reset
  logic            clr_q;
  logic [SetW-1:0] clr_idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + SetW'(1);
      if (clr_idx_q == SetW'(NSets - 1)) clr_q <= 1'b0;
    end
  end

  // stage control
  logic s1_q, busy;
  logic out_valid_q;
  assign busy = s1_q;
  assign in_ready_o = !busy && !clr_q && (!out_valid_q || out_ready_i);
  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // tag memory, one row per set holding all ways
  logic [ADDR_BITS-1:0] tag_mem [NSets][MAX_WAYS];
  logic [ADDR_BITS-1:0] rd_tag_q [MAX_WAYS];
  // line-state memory, one row per set: mark count, marks, valid bits
  logic [MetaW-1:0]     meta_mem [NSets];
  logic [MetaW-1:0]     rd_meta_q, wr_meta;
  logic [SetW-1:0]      set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic                 op_q;
  logic                 pol_s_q;
  logic [1:0]           wayb_s_q;

  logic                 wr_en;
  logic [WayW-1:0]      wr_way;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int w = 0; w < MAX_WAYS; w++) rd_tag_q[w] <= tag_mem[set_in][w];
      rd_meta_q <= meta_mem[set_in];
      set_q <= set_in;
      tag_q <= tag_in;
      op_q <= operation_i;
      pol_s_q <= policy_q;
      wayb_s_q <= wayb_q;
    end
    if (wr_en) tag_mem[set_q][wr_way] <= tag_q;
    if (clr_q) meta_mem[clr_idx_q] <= '0;
    else if (s1_q) meta_mem[set_q] <= wr_meta;
  end

  // lookup, replacement and mark update
  logic [4:0]          ways;
  logic [MAX_WAYS-1:0] inuse, vrow, mrow, match, mnew, vnew;
  logic [3:0]          cnt, cnew;
  logic                hit, alloc, mem, fill, found, two;
  logic [WayW-1:0]     hway, vway, tway;
  always_comb begin
    ways = 5'd1 << wayb_s_q;
    if (32'(ways) > MAX_WAYS) ways = 5'(MAX_WAYS);
    vrow = rd_meta_q[MAX_WAYS-1:0];
    mrow = rd_meta_q[2*MAX_WAYS-1:MAX_WAYS];
    cnt = rd_meta_q[MetaW-1:2*MAX_WAYS];
    hway = '0;
    hit = 1'b0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      inuse[w] = (32'(w) < 32'(ways));
      match[w] = inuse[w] && vrow[w] && (rd_tag_q[w] == tag_q);
      if (match[w]) begin
        hit = 1'b1;
        hway = WayW'(w);
      end
    end
    vway = '0;
    found = 1'b0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (inuse[w] && (!vrow[w] || !mrow[w])) begin
        vway = WayW'(w);
        found = 1'b1;
      end
    end
    if (!found) vway = '0;
    two = 1'b0;
    if (pol_s_q == sacbp_pkg::PolicyAlloc) begin
      alloc = !hit;
      mem = !hit;
    end else if (op_q == sacbp_pkg::OpWrite) begin
      alloc = 1'b0;
      mem = 1'b1;
    end else begin
      alloc = !hit;
      mem = !hit;
      two = !hit;
    end
    fill = alloc;
    tway = hit ? hway : vway;
    mnew = mrow;
    cnew = cnt;
    if (hit || alloc) begin
      if (!mrow[tway]) cnew = cnt + 4'd1;
      if ({1'b0, cnew} >= ways) begin
        mnew = mrow & ~inuse;
        cnew = 4'd1;
      end
      mnew[tway] = 1'b1;
    end
    vnew = vrow;
    if (alloc) vnew[vway] = 1'b1;
    wr_meta = {cnew, mnew, vnew};
    wr_en = s1_q && alloc;
    wr_way = vway;
  end

  // counters and output register
  logic [CntW-1:0] hits_q, mems_q, looks_q, l1;
  logic            hit_q, mem_q, fill_q;
  assign l1 = sacbp_pkg::sat_inc(looks_q, 1'b1);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      out_valid_q <= 1'b0;
      hits_q <= '0;
      mems_q <= '0;
      looks_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      s1_q <= accept;
      if (s1_q) begin
        hits_q <= sacbp_pkg::sat_inc(hits_q, hit);
        mems_q <= sacbp_pkg::sat_inc(mems_q, mem);
        looks_q <= sacbp_pkg::sat_inc(l1, two);
        out_valid_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      hit_q <= hit;
      mem_q <= mem;
      fill_q <= fill;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o = hit_q;
  assign memory_access_o = mem_q;
  assign filled_o = fill_q;
  assign hit_count_o = hits_q;
  assign memory_count_o = mems_q;
  assign lookup_count_o = looks_q;
endmodule
`default_nettype wire

>>> tb/sv/tb_set_assoc_cache_bit_plru.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_set_assoc_cache_bit_plru;

  localparam int NumSets = 1 << sacbp_pkg::MaxSetBits;
  localparam int NumLines = NumSets * sacbp_pkg::MaxWays;
  localparam int WatchLimit = 2000;

  typedef struct packed {
    logic        hit;
    logic        mem;
    logic        fill;
    logic [31:0] hits;
    logic [31:0] mems;
    logic [31:0] looks;
  } access_res_t;

  // directory predictor with its own copy of tags, marks and counters
  class cache_scoreboard;
    logic [sacbp_pkg::AddrBits-1:0] tags[NumLines];
    bit                  valid[NumLines];
    bit                  mark[NumLines];
    logic [3:0]          nmarked[NumSets];
    logic [31:0]         hits, mems, looks;
    bit                  policy;
    logic [3:0]          off_bits, set_bits;
    logic [1:0]          way_bits;
    access_res_t         pending[$];
    int                  errors;
    int                  checked;

    function new();
      foreach (valid[i]) begin
        valid[i] = 0;
        mark[i] = 0;
        tags[i] = '0;
      end
      foreach (nmarked[i]) nmarked[i] = 0;
      hits = 0;
      mems = 0;
      looks = 0;
      policy = 0;
      off_bits = 5;
      set_bits = 8;
      way_bits = 3;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        sacbp_pkg::RegPolicy: policy = val[0];
        sacbp_pkg::RegOffset: off_bits = val;
        sacbp_pkg::RegSetBits: set_bits = val;
        sacbp_pkg::RegWayBits: way_bits = val[1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hffffffff) ? v : v + 32'd1;
    endfunction

    function int nways();
      int w;
      w = 1 << way_bits;
      return (w > sacbp_pkg::MaxWays) ? sacbp_pkg::MaxWays : w;
    endfunction

    function void touch(int s, int w, int ways);
      int b;
      b = s * sacbp_pkg::MaxWays;
      if (!mark[b + w]) nmarked[s] = nmarked[s] + 4'd1;
      if (nmarked[s] >= ways) begin
        for (int i = 0; i < ways; i++) mark[b + i] = 0;
        nmarked[s] = 1;
      end
      mark[b + w] = 1;
    endfunction

    function bit probe(int s, logic [sacbp_pkg::AddrBits-1:0] tg, bit alloc);
      int ways, b, victim;
      ways = nways();
      b = s * sacbp_pkg::MaxWays;
      victim = 0;
      for (int i = 0; i < ways; i++) begin
        if (valid[b + i] && tags[b + i] == tg) begin
          touch(s, i, ways);
          return 1;
        end
      end
      if (alloc) begin
        for (int i = 0; i < ways; i++) begin
          if (!valid[b + i] || !mark[b + i]) begin
            victim = i;
            break;
          end
        end
        touch(s, victim, ways);
        valid[b + victim] = 1;
        tags[b + victim] = tg;
      end
      return 0;
    endfunction

    // note an accepted access and queue its expected result
    function void note_access(bit wr, logic [sacbp_pkg::AddrBits-1:0] addr);
      int sb, s;
      logic [sacbp_pkg::AddrBits-1:0] tg;
      access_res_t r;
      sb = (set_bits > sacbp_pkg::MaxSetBits) ? sacbp_pkg::MaxSetBits : set_bits;
      s = int'((addr >> off_bits) & ((48'd1 << sb) - 48'd1));
      tg = addr >> (off_bits + sb);
      r = '0;
      looks = bump(looks);
      if (policy == sacbp_pkg::PolicyAlloc) begin
        r.hit = probe(s, tg, 1);
        r.mem = !r.hit;
        r.fill = !r.hit;
      end else if (wr == sacbp_pkg::OpWrite) begin
        r.hit = probe(s, tg, 0);
        r.mem = 1;
      end else begin
        r.hit = probe(s, tg, 0);
        if (!r.hit) begin
          r.mem = 1;
          looks = bump(looks);
          void'(probe(s, tg, 1));
          r.fill = 1;
        end
      end
      if (r.hit) hits = bump(hits);
      if (r.mem) mems = bump(mems);
      r.hits = hits;
      r.mems = mems;
      r.looks = looks;
      pending.push_back(r);
    endfunction

    // compare one accepted result against the oldest expectation
    function void check_result(access_res_t a);
      access_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, a.hit);
        errors++;
      end
      if (a.mem !== e.mem) begin
        $error("memory_access exp %0d got %0d", e.mem, a.mem);
        errors++;
      end
      if (a.fill !== e.fill) begin
        $error("filled exp %0d got %0d", e.fill, a.fill);
        errors++;
      end
      if (a.hits !== e.hits) begin
        $error("hit_count exp %0d got %0d", e.hits, a.hits);
        errors++;
      end
      if (a.mems !== e.mems) begin
        $error("memory_count exp %0d got %0d", e.mems, a.mems);
        errors++;
      end
      if (a.looks !== e.looks) begin
        $error("lookup_count exp %0d got %0d", e.looks, a.looks);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                cfg_valid_i = 0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [3:0]          cfg_data_i = '0;
  logic                in_valid_i = 0;
  logic                in_ready_o;
  logic                operation_i = 0;
  logic [sacbp_pkg::AddrBits-1:0] address_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 0;
  logic                hit_o, memory_access_o, filled_o;
  logic [31:0]         hit_count_o, memory_count_o, lookup_count_o;

  cache_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  rx_enable = 0;
  int  words_in = 0;

  set_assoc_cache_bit_plru uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .operation_i, .address_i, .out_valid_o, .out_ready_i,
    .hit_o, .memory_access_o, .filled_o, .hit_count_o, .memory_count_o,
    .lookup_count_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stall per word, check on accept
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{hit_o, memory_access_o, filled_o, hit_count_o, memory_count_o,
                        lookup_count_o});
    end
  end

  initial begin
    int stall;
    wait (rx_enable);
    forever begin
      stall = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready_i <= 0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("tb_set_assoc_cache_bit_plru NOT OK");
      $finish;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [3:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // valid stays high after the accept; the next call with a gap or drain() drops it
  task automatic send_word(bit wr, logic [sacbp_pkg::AddrBits-1:0] addr, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    operation_i <= wr;
    address_i <= addr;
    in_valid_i <= 1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_access(wr, addr);
    words_in++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [sacbp_pkg::AddrBits-1:0] rand_addr();
    return sacbp_pkg::AddrBits'({$urandom(), $urandom()});
  endfunction

  // address built from a small pool of tags and sets so lines get reused
  function automatic logic [sacbp_pkg::AddrBits-1:0] pool_addr(logic [3:0] ob,
                                                              logic [3:0] sbits);
    logic [sacbp_pkg::AddrBits-1:0] a;
    int sb_use;
    sb_use = (sbits > sacbp_pkg::MaxSetBits) ? sacbp_pkg::MaxSetBits : sbits;
    a = sacbp_pkg::AddrBits'($urandom_range(0, 11)) << (ob + sb_use);
    a |= sacbp_pkg::AddrBits'($urandom_range(0, 3)) << ob;
    a |= sacbp_pkg::AddrBits'($urandom()) & ((48'd1 << ob) - 48'd1);
    if ($urandom_range(0, 15) == 0) a = rand_addr();
    return a;
  endfunction

  initial begin
    logic [3:0] ob, sbits;
    logic [1:0] wb;
    bit burst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    rx_enable = 1;

    // directed: address extremes, both ops, same-set pressure, way-0 fallback
    send_word(0, '0, 0);
    send_word(1, '1, 0);
    send_word(0, '1, 1);
    send_word(1, 48'h5555_5555_5555, 1);
    send_word(0, 48'haaaa_aaaa_aaaa, 0);
    for (int i = 0; i < 10; i++) send_word(i[0], sacbp_pkg::AddrBits'(i) << 13, 1);
    drain();
    write_cfg(sacbp_pkg::RegWayBits, 4'd3);
    write_cfg(sacbp_pkg::RegSetBits, 4'd15);
    write_cfg(sacbp_pkg::RegOffset, 4'd15);
    send_word(0, '1, 0);
    send_word(0, 48'h1234_5678_9abc, 0);
    drain();
    // marks from eight ways left, then shrink to one way: overflow and no victim
    write_cfg(sacbp_pkg::RegWayBits, 4'd0);
    write_cfg(sacbp_pkg::RegOffset, 4'd5);
    write_cfg(sacbp_pkg::RegSetBits, 4'd8);
    send_word(0, 48'h4000_0000, 0);
    send_word(1, 48'h8000_0000, 0);
    drain();
    write_cfg(sacbp_pkg::RegPolicy, 4'd1);
    send_word(0, 48'hc000_0000, 0);
    send_word(1, 48'hc000_0000, 0);
    send_word(0, 48'hc000_0000, 0);
    drain();

    // random phases across settings, extremes included
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin ob = 4'd0; sbits = 4'd0; wb = 2'd0; end
        1: begin ob = 4'd12; sbits = 4'd8; wb = 2'd3; end
        2: begin ob = 4'd15; sbits = 4'd15; wb = 2'd2; end
        default: begin
          ob = 4'($urandom_range(0, 15));
          sbits = 4'($urandom_range(0, 15));
          wb = 2'($urandom_range(0, 3));
        end
      endcase
      write_cfg(sacbp_pkg::RegPolicy, 4'(ph % 2));
      write_cfg(sacbp_pkg::RegOffset, ob);
      write_cfg(sacbp_pkg::RegSetBits, sbits);
      write_cfg(sacbp_pkg::RegWayBits, 4'(wb));
      for (int i = 0; i < 152; i++) begin
        burst = (i % 40) < 12;
        send_word(1'($urandom_range(0, 1)), pool_addr(ob, sbits), burst);
      end
      drain();
    end

    $display("run covered %0d accesses and %0d checked results in directed cases",
             words_in, sb.checked);
    $display("and 12 random register phases with both policies");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_set_assoc_cache_bit_plru OK");
    else
      $display("tb_set_assoc_cache_bit_plru NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
hdl/sacbp_pkg.sv
hdl/set_assoc_cache_bit_plru.sv
tb/sv/tb_set_assoc_cache_bit_plru.sv
